FILE: hdl/srhc_pkg.sv
package srhc_pkg;

  localparam int unsigned MAX_REGIONS_DEFAULT = 64;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned SQ_W     = 2 * SIZE_W;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned DSQ_W    = 2 * DIST_W;
  localparam int unsigned AREA_W   = 40;
  localparam int unsigned SUM_W    = 46;
  localparam int unsigned OCNT_W   = 7;
  localparam int unsigned OIDX_W   = 6;

  // circle area 804/256 * r*r, rectangle 4*a*b, both with 8 fractional bits
  localparam logic [9:0]  CIRCLE_AREA_K   = 10'd804;
  localparam int unsigned RECT_AREA_SHIFT = 10;

  localparam logic [OCNT_W-1:0] OCNT_MAX = 7'd127;

  localparam logic OP_INSERT    = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_MUL,
    ST_INS_SCALE,
    ST_INS_COMMIT,
    ST_QUERY,
    ST_DONE
  } srhc_state_t;

  typedef struct packed {
    logic load_in;
    logic ins_mul;
    logic ins_scale;
    logic ins_commit;
    logic scan_en;
    logic out_load;
  } srhc_cmd_t;

  typedef struct packed {
    logic op_query;
    logic reject;
    logic scan_idle;
    logic out_busy;
  } srhc_stat_t;

  typedef struct packed {
    logic                      rect;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]         a;
    logic [SIZE_W-1:0]         b;
    logic [SQ_W-1:0]           rr;
  } srhc_entry_t;

endpackage

FILE: hdl/srhc_ctrl.sv
module srhc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srhc_pkg::srhc_stat_t stat,
  output srhc_pkg::srhc_cmd_t  cmd
);
  import srhc_pkg::*;

  srhc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_INS_MUL;
        end
      end
      ST_INS_MUL: begin
        // the latched op decides the path
        if (stat.op_query) begin
          state_next = ST_QUERY;
        end else if (stat.reject) begin
          state_next = ST_DONE;
        end else begin
          cmd.ins_mul = 1'b1;
          state_next  = ST_INS_SCALE;
        end
      end
      ST_INS_SCALE: begin
        cmd.ins_scale = 1'b1;
        state_next    = ST_INS_COMMIT;
      end
      ST_INS_COMMIT: begin
        cmd.ins_commit = 1'b1;
        state_next     = ST_DONE;
      end
      ST_QUERY: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_idle) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/srhc_dp.sv
module srhc_dp #(
  parameter int unsigned MAX_REGIONS = srhc_pkg::MAX_REGIONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  srhc_pkg::srhc_cmd_t                cmd,
  output srhc_pkg::srhc_stat_t               stat,
  input  logic                               op,
  input  logic                               shape,
  input  logic signed [srhc_pkg::COORD_W-1:0] pos_x,
  input  logic signed [srhc_pkg::COORD_W-1:0] pos_y,
  input  logic [srhc_pkg::SIZE_W-1:0]        size_a,
  input  logic [srhc_pkg::SIZE_W-1:0]        size_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               status,
  output logic [srhc_pkg::OCNT_W-1:0]        hit_count,
  output logic [srhc_pkg::OCNT_W-1:0]        region_count,
  output logic [srhc_pkg::SUM_W-1:0]         total_area,
  output logic [srhc_pkg::OIDX_W-1:0]        best_index,
  output logic                               best_valid
);
  import srhc_pkg::*;

  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGIONS);

  function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    logic [OCNT_W-1:0] r;
    if (32'(v) > 32'(OCNT_MAX)) begin
      r = OCNT_MAX;
    end else begin
      r = OCNT_W'(v);
    end
    return r;
  endfunction

  // request latch
  logic                      op_q;
  logic                      shape_q;
  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W-1:0] py_q;
  logic [SIZE_W-1:0]         sa_q;
  logic [SIZE_W-1:0]         sb_q;
  logic                      reject_q;

  // table bookkeeping
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  area_sum;
  logic [IDX_W-1:0]  largest_index;
  logic [AREA_W-1:0] largest_area;

  // insert arithmetic
  logic [SIZE_W-1:0] mul_b;
  logic [SQ_W-1:0]   prod_w;
  logic [SQ_W-1:0]   prod;
  logic [AREA_W-1:0] area_circ;
  logic [AREA_W-1:0] area;
  logic [SUM_W:0]    sum_w;
  logic              table_full;
  srhc_entry_t       wr_entry;

  srhc_entry_t mem [MAX_REGIONS];

  // query scan
  logic [CNT_W-1:0]  scan_cnt;
  logic              issue;
  srhc_entry_t       rd_q;
  logic              v1, v2, v3, v4, v5;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]  adx_w, ady_w;
  logic [DIST_W-1:0] adx2, ady2, ady3;
  logic              rect2, rect3, rect4;
  logic              rin2, rin3, rin4;
  logic [SQ_W-1:0]   rr2, rr3, rr4;
  logic [DSQ_W-1:0]  sqx3, sqx4, sqy4;
  logic              hit5;
  logic [CNT_W-1:0]  hits;

  assign table_full = (count >= CNT_FULL);
  assign mul_b      = (shape_q == SHAPE_RECT) ? sb_q : sa_q;
  assign prod_w     = sa_q * mul_b;
  assign area_circ  = AREA_W'(prod) * AREA_W'(CIRCLE_AREA_K);
  assign sum_w      = {1'b0, area_sum} + (SUM_W + 1)'(area);

  always_comb begin
    wr_entry.rect = shape_q;
    wr_entry.cx   = px_q;
    wr_entry.cy   = py_q;
    wr_entry.a    = sa_q;
    wr_entry.b    = (shape_q == SHAPE_RECT) ? sb_q : '0;
    wr_entry.rr   = prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= op;
      shape_q  <= shape;
      px_q     <= pos_x;
      py_q     <= pos_y;
      sa_q     <= size_a;
      sb_q     <= size_b;
      reject_q <= (op == OP_INSERT) && table_full;
    end
    if (cmd.ins_mul) begin
      prod <= prod_w;
    end
    if (cmd.ins_scale) begin
      area <= (shape_q == SHAPE_RECT) ? {prod, {RECT_AREA_SHIFT{1'b0}}} : area_circ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      area_sum      <= '0;
      largest_index <= '0;
      largest_area  <= '0;
    end else if (cmd.ins_commit) begin
      count <= count + CNT_W'(1);
      if (sum_w[SUM_W]) begin
        area_sum <= '1;
      end else begin
        area_sum <= sum_w[SUM_W-1:0];
      end
      if ((count == '0) || (area > largest_area)) begin
        largest_area  <= area;
        largest_index <= count[IDX_W-1:0];
      end
    end
  end

  // region store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      mem[count[IDX_W-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q <= mem[scan_cnt[IDX_W-1:0]];
    end
  end

  assign issue = cmd.scan_en && (scan_cnt < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (cmd.load_in) begin
      scan_cnt <= '0;
    end else if (issue) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
  end

  // containment pipeline
  assign dx    = {px_q[COORD_W-1], px_q} - {rd_q.cx[COORD_W-1], rd_q.cx};
  assign dy    = {py_q[COORD_W-1], py_q} - {rd_q.cy[COORD_W-1], rd_q.cy};
  assign adx_w = dx[COORD_W] ? (COORD_W + 1)'(-dx) : (COORD_W + 1)'(dx);
  assign ady_w = dy[COORD_W] ? (COORD_W + 1)'(-dy) : (COORD_W + 1)'(dy);

  always_ff @(posedge clk) begin
    adx2  <= adx_w[DIST_W-1:0];
    ady2  <= ady_w[DIST_W-1:0];
    rect2 <= rd_q.rect;
    rin2  <= (adx_w <= (COORD_W + 1)'(rd_q.a)) && (ady_w <= (COORD_W + 1)'(rd_q.b));
    rr2   <= rd_q.rr;

    sqx3  <= DSQ_W'(adx2) * DSQ_W'(adx2);
    ady3  <= ady2;
    rect3 <= rect2;
    rin3  <= rin2;
    rr3   <= rr2;

    sqy4  <= DSQ_W'(ady3) * DSQ_W'(ady3);
    sqx4  <= sqx3;
    rect4 <= rect3;
    rin4  <= rin3;
    rr4   <= rr3;

    hit5  <= rect4 ? rin4
                   : (({1'b0, sqx4} + {1'b0, sqy4}) <= (DSQ_W + 1)'(rr4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      hits <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.load_in) begin
        hits <= '0;
      end else if (v5 && hit5) begin
        hits <= hits + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= reject_q ? STATUS_FULL : STATUS_OK;
      hit_count    <= (op_q == OP_QUERY) ? sat_cnt(hits) : '0;
      region_count <= sat_cnt(count);
      total_area   <= area_sum;
      best_index   <= (count != '0) ? OIDX_W'(largest_index) : '0;
      best_valid   <= (count != '0);
    end
  end

  assign stat.op_query  = (op_q == OP_QUERY);
  assign stat.reject    = reject_q;
  assign stat.scan_idle = (scan_cnt >= count) && !(v1 || v2 || v3 || v4 || v5);
  assign stat.out_busy  = out_valid && !out_ready;

endmodule

FILE: hdl/sensor_region_hit_counter.sv
// path from request accept to result valid: insert through the multiply, scale and commit steps,
// rejected insert straight to the result, query through the table walk over the n stored regions
// throughput: one request in flight, the next accept comes in the cycle after the result loads;
// query time set by the one-read-per-cycle table walk over the n stored regions,
// insert time by the area multiply, scale and commit steps; a stalled result holds the sequencer
// reset: synchronous, active high; clears region count, area total and largest entry;
// table contents are not cleared and are only read below the region count
module sensor_region_hit_counter #(
  parameter int unsigned MAX_REGIONS = srhc_pkg::MAX_REGIONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic                               shape,
  input  logic signed [srhc_pkg::COORD_W-1:0] pos_x,
  input  logic signed [srhc_pkg::COORD_W-1:0] pos_y,
  input  logic [srhc_pkg::SIZE_W-1:0]        size_a,
  input  logic [srhc_pkg::SIZE_W-1:0]        size_b,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               status,
  output logic [srhc_pkg::OCNT_W-1:0]        hit_count,
  output logic [srhc_pkg::OCNT_W-1:0]        region_count,
  output logic [srhc_pkg::SUM_W-1:0]         total_area,
  output logic [srhc_pkg::OIDX_W-1:0]        best_index,
  output logic                               best_valid
);
  import srhc_pkg::*;

  // controller and datapath talk only through these two bundles
  srhc_cmd_t  cmd;
  srhc_stat_t stat;

  // sequencer: request latch, insert multiply steps, table walk, result hand-off;
  // a new request may be taken while the previous result still waits downstream
  srhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: region store, area arithmetic with saturating total,
  // largest-area tracking (earliest wins ties) and a five-stage
  // containment pipeline fed one table entry per cycle
  srhc_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .shape        (shape),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .size_a       (size_a),
    .size_b       (size_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .hit_count    (hit_count),
    .region_count (region_count),
    .total_area   (total_area),
    .best_index   (best_index),
    .best_valid   (best_valid)
  );

endmodule

FILE: tb/sensor_region_hit_counter_tb.sv
module sensor_region_hit_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srhc_pkg::*;

  localparam int     CLK_PERIOD      = 10;
  localparam int     RESET_CYCLES    = 5;
  localparam int     TABLE_DEPTH     = MAX_REGIONS_DEFAULT;
  localparam int     RANDOM_ITEMS    = 1280;
  localparam int     HOLD_OFF_CYCLES = 400;
  // longest quiet spell of a correct run is the hold-off plus one full table walk
  localparam int     WATCHDOG_LIMIT  = 5000;
  localparam int     DRAIN_CYCLES    = 100;
  // areas carry 8 fractional bits: pi as 804/256, rectangle 4*a*b
  localparam longint CIRCLE_Q8       = 804;
  localparam longint RECT_Q8         = 1024;
  localparam longint AREA_LIMIT      = (64'd1 << SUM_W) - 1;
  localparam int     COUNT_LIMIT     = 127;

  // one request as offered on the input channel
  typedef struct {
    logic                      op;
    logic                      shape;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         a;
    logic [SIZE_W-1:0]         b;
  } region_req_t;

  // one coverage summary as returned on the output channel
  typedef struct {
    logic              status;
    logic [OCNT_W-1:0] hits;
    logic [OCNT_W-1:0] regions;
    logic [SUM_W-1:0]  area;
    logic [OIDX_W-1:0] best_idx;
    logic              best_ok;
  } coverage_t;

  // directed row: the summary is typed in only where it is obvious
  typedef struct {
    region_req_t req;
    bit          typed;
    coverage_t   fixed;
  } directed_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid;
  logic                      in_ready;
  logic                      op;
  logic                      shape;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [SIZE_W-1:0]         size_a;
  logic [SIZE_W-1:0]         size_b;
  logic                      out_valid;
  logic                      out_ready;
  logic                      status;
  logic [OCNT_W-1:0]         hit_count;
  logic [OCNT_W-1:0]         region_count;
  logic [SUM_W-1:0]          total_area;
  logic [OIDX_W-1:0]         best_index;
  logic                      best_valid;

  // own copy of the region table and running totals
  logic                      region_is_rect [TABLE_DEPTH];
  logic signed [COORD_W-1:0] region_cx      [TABLE_DEPTH];
  logic signed [COORD_W-1:0] region_cy      [TABLE_DEPTH];
  logic [SIZE_W-1:0]         region_a       [TABLE_DEPTH];
  logic [SIZE_W-1:0]         region_b       [TABLE_DEPTH];
  int                        regions_held = 0;
  longint                    area_total   = 0;
  int                        largest_slot = 0;
  longint                    largest_area = 0;

  coverage_t     coverage_summary_q [$];
  directed_row_t directed_rows      [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int idle_cycles    = 0;
  bit send_burst     = 1'b0;
  bit recv_burst     = 1'b0;
  bit hold_off_req   = 1'b0;

  sensor_region_hit_counter u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .shape       (shape),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .size_a      (size_a),
    .size_b      (size_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .hit_count   (hit_count),
    .region_count(region_count),
    .total_area  (total_area),
    .best_index  (best_index),
    .best_valid  (best_valid)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // apply one accepted request to the table copy and work out its summary
  function automatic coverage_t apply_region_request(input region_req_t r);
    coverage_t c;
    longint    px, py, dx, dy, ra, rb, area;
    int        hits, i;
    c.status = STATUS_OK;
    hits = 0;
    if (r.op == OP_INSERT) begin
      if (regions_held >= TABLE_DEPTH) begin
        // full table: rejected, nothing changes
        c.status = STATUS_FULL;
      end else begin
        region_is_rect[regions_held] = r.shape;
        region_cx[regions_held] = r.x;
        region_cy[regions_held] = r.y;
        region_a[regions_held] = r.a;
        // half-height means nothing for a circle
        region_b[regions_held] = (r.shape == SHAPE_RECT) ? r.b : '0;
        ra = longint'(r.a);
        rb = longint'(region_b[regions_held]);
        area = (r.shape == SHAPE_RECT) ? RECT_Q8 * ra * rb : CIRCLE_Q8 * ra * ra;
        // strictly larger only, so the earliest entry keeps a tie
        if (regions_held == 0 || area > largest_area) begin
          largest_area = area;
          largest_slot = regions_held;
        end
        area_total = area_total + area;
        if (area_total > AREA_LIMIT) area_total = AREA_LIMIT;
        regions_held++;
      end
    end else begin
      px = longint'(r.x);
      py = longint'(r.y);
      for (i = 0; i < regions_held; i++) begin
        dx = px - longint'(region_cx[i]);
        dy = py - longint'(region_cy[i]);
        ra = longint'(region_a[i]);
        rb = longint'(region_b[i]);
        // boundaries count as inside for both shapes
        if (region_is_rect[i]) begin
          if (dx >= -ra && dx <= ra && dy >= -rb && dy <= rb) hits++;
        end else begin
          if (dx * dx + dy * dy <= ra * ra) hits++;
        end
      end
    end
    c.hits     = OCNT_W'((hits > COUNT_LIMIT) ? COUNT_LIMIT : hits);
    c.regions  = OCNT_W'((regions_held > COUNT_LIMIT) ? COUNT_LIMIT : regions_held);
    c.area     = area_total[SUM_W-1:0];
    c.best_idx = (regions_held != 0) ? largest_slot[OIDX_W-1:0] : '0;
    c.best_ok  = (regions_held != 0);
    return c;
  endfunction

  // mostly small sizes, some medium, a few across the whole range
  function automatic logic [SIZE_W-1:0] draw_size();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick < 5) return SIZE_W'($urandom_range(0, 300));
    if (pick < 7) return SIZE_W'($urandom_range(0, 4095));
    return SIZE_W'($urandom);
  endfunction

  // random request: inserts now and then, queries often aimed at stored edges
  function automatic region_req_t random_request();
    region_req_t q;
    int          pick, slot;
    longint      px, py, ra, rb, dx, dy, nudge;
    q.op    = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_QUERY;
    q.shape = 1'($urandom_range(0, 1));
    q.x     = COORD_W'($urandom);
    q.y     = COORD_W'($urandom);
    q.a     = SIZE_W'($urandom);
    q.b     = SIZE_W'($urandom);
    if (q.op == OP_INSERT) begin
      // most regions sit in one cluster so that they overlap
      if ($urandom_range(0, 3) != 0) begin
        q.x = COORD_W'($urandom_range(0, 1023) - 512);
        q.y = COORD_W'($urandom_range(0, 1023) - 512);
      end
      q.a = draw_size();
      q.b = draw_size();
    end else begin
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
        q.x = COORD_W'($urandom_range(0, 2047) - 1024);
        q.y = COORD_W'($urandom_range(0, 2047) - 1024);
      end else if (pick >= 2 && regions_held > 0) begin
        // a point on, just inside or just outside the edge of a stored region
        slot  = $urandom_range(0, regions_held - 1);
        ra    = longint'(region_a[slot]);
        rb    = longint'(region_b[slot]);
        px    = longint'(region_cx[slot]);
        py    = longint'(region_cy[slot]);
        nudge = longint'($urandom_range(0, 2)) - 1;
        if (region_is_rect[slot]) begin
          if ($urandom_range(0, 1)) begin
            px = px + ($urandom_range(0, 1) ? ra : -ra) + nudge;
            py = py + longint'($urandom_range(0, int'(2 * rb))) - rb;
          end else begin
            px = px + longint'($urandom_range(0, int'(2 * ra))) - ra;
            py = py + ($urandom_range(0, 1) ? rb : -rb) + nudge;
          end
        end else begin
          dx = longint'($urandom_range(0, int'(2 * ra))) - ra;
          dy = longint'($sqrt(real'(ra * ra - dx * dx)));
          if ($urandom_range(0, 1)) dy = -dy;
          px = px + dx;
          py = py + dy + nudge;
        end
        q.x = COORD_W'((px < -32768) ? -32768 : ((px > 32767) ? 32767 : px));
        q.y = COORD_W'((py < -32768) ? -32768 : ((py > 32767) ? 32767 : py));
      end
    end
    return q;
  endfunction

  function automatic void add_row(input bit typed, input logic o, input logic s,
                                  input int x, input int y, input int a, input int b,
                                  input logic st = STATUS_OK, input int hits = 0,
                                  input int regs = 0, input longint area = 0,
                                  input int bidx = 0, input logic bok = 1'b0);
    directed_row_t row;
    row.req.op         = o;
    row.req.shape      = s;
    row.req.x          = COORD_W'(x);
    row.req.y          = COORD_W'(y);
    row.req.a          = SIZE_W'(a);
    row.req.b          = SIZE_W'(b);
    row.typed          = typed;
    row.fixed.status   = st;
    row.fixed.hits     = OCNT_W'(hits);
    row.fixed.regions  = OCNT_W'(regs);
    row.fixed.area     = SUM_W'(area);
    row.fixed.best_idx = OIDX_W'(bidx);
    row.fixed.best_ok  = bok;
    directed_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // offer one request after a random gap and hold it until taken
  task automatic send_request(input directed_row_t row);
    coverage_t predicted;
    int        gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= row.req.op;
    shape    <= row.req.shape;
    pos_x    <= row.req.x;
    pos_y    <= row.req.y;
    size_a   <= row.req.a;
    size_b   <= row.req.b;
    do @(posedge clk); while (in_ready !== 1'b1);
    // the table copy moves on even where the summary is typed in
    predicted = apply_region_request(row.req);
    coverage_summary_q.push_back(row.typed ? row.fixed : predicted);
  endtask

  // drop the request line and wait for every outstanding summary
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (coverage_summary_q.size() != 0) @(posedge clk);
  endtask

  // request side
  initial begin
    directed_row_t row;
    int            n;
    in_valid = 1'b0;
    op       = OP_INSERT;
    shape    = SHAPE_CIRCLE;
    pos_x    = '0;
    pos_y    = '0;
    size_a   = '0;
    size_b   = '0;

    // empty table, then a zero-size circle at the origin
    add_row(1'b1, OP_QUERY,  SHAPE_CIRCLE, 0, 0, 0, 0, STATUS_OK, 0, 0, 0, 0, 1'b0);
    add_row(1'b1, OP_INSERT, SHAPE_CIRCLE, 0, 0, 0, 0, STATUS_OK, 0, 1, 0, 0, 1'b1);
    add_row(1'b1, OP_QUERY,  SHAPE_CIRCLE, 0, 0, 0, 0, STATUS_OK, 1, 1, 0, 0, 1'b1);
    add_row(1'b1, OP_QUERY,  SHAPE_CIRCLE, 1, 0, 0, 0, STATUS_OK, 0, 1, 0, 0, 1'b1);
    // largest rectangle and circle at opposite corners
    add_row(1'b0, OP_INSERT, SHAPE_RECT,   -32768, -32768, 32767, 32767);
    add_row(1'b0, OP_INSERT, SHAPE_CIRCLE, 32767, 32767, 32767, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, -1, -1, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 0, -1, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 32767, 32767, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, -32768, 32767, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 32767, -32768, 0, 0);
    // circle edge by a 3-4-5 triangle
    add_row(1'b0, OP_INSERT, SHAPE_CIRCLE, 100, -100, 5, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 103, -96, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 104, -96, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 100, -95, 0, 0);
    // zero-width rectangle is a vertical line
    add_row(1'b0, OP_INSERT, SHAPE_RECT,   0, 0, 0, 10);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 0, 10, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 0, -11, 0, 0);
    // shape and sizes are ignored on a query
    add_row(1'b0, OP_QUERY,  SHAPE_RECT,   0, -10, 32767, 32767);
    // equal largest area: the earlier entry stays
    add_row(1'b0, OP_INSERT, SHAPE_RECT,   1000, -1000, 32767, 32767);
    // half-height on a circle is dropped
    add_row(1'b0, OP_INSERT, SHAPE_CIRCLE, 7, 7, 3, 32767);
    add_row(1'b0, OP_QUERY,  SHAPE_CIRCLE, 7, 10, 0, 0);
    // single-point rectangle in a corner
    add_row(1'b0, OP_INSERT, SHAPE_RECT,   -32768, 32767, 0, 0);
    add_row(1'b0, OP_QUERY,  SHAPE_RECT,   -32768, 32767, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) send_request(directed_rows[k]);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long output stall while requests keep coming
      if (n == 300 || n == 900) hold_off_req = 1'b1;
      // let the block run dry now and then
      if (n == 600 || n == 1100) drain_requests();
      row.req   = random_request();
      row.typed = 1'b0;
      send_request(row);
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("PASS sensor_region_hit_counter");
    else $display("FAIL sensor_region_hit_counter");
    $finish;
  end

  // result side: random stalls, calm stretches and the long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // compare each accepted summary with the oldest one outstanding
  always @(posedge clk) begin
    coverage_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (coverage_summary_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
        end else begin
          want = coverage_summary_q.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("result %0d status %0b, want %0b",
                                    results_seen, status, want.status));
          if (hit_count !== want.hits)
            flag_mismatch($sformatf("result %0d hit_count %0d, want %0d",
                                    results_seen, hit_count, want.hits));
          if (region_count !== want.regions)
            flag_mismatch($sformatf("result %0d region_count %0d, want %0d",
                                    results_seen, region_count, want.regions));
          if (total_area !== want.area)
            flag_mismatch($sformatf("result %0d total_area %0d, want %0d",
                                    results_seen, total_area, want.area));
          if (best_index !== want.best_idx)
            flag_mismatch($sformatf("result %0d best_index %0d, want %0d",
                                    results_seen, best_index, want.best_idx));
          if (best_valid !== want.best_ok)
            flag_mismatch($sformatf("result %0d best_valid %0b, want %0b",
                                    results_seen, best_valid, want.best_ok));
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  // watchdog: too long without any request or result moving
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL sensor_region_hit_counter");
    $finish;
  end

endmodule

FILE: files.f
hdl/srhc_pkg.sv
hdl/srhc_ctrl.sv
hdl/srhc_dp.sv
hdl/sensor_region_hit_counter.sv
tb/sensor_region_hit_counter_tb.sv
